### hdl/acd_pkg.sv
`default_nettype none
package acd_pkg;
	localparam int ITERATIONS = 23;
	localparam int STEPS = (ITERATIONS < 30) ? ITERATIONS : 30;
	localparam int DW = 36;
	localparam int SQ_STEPS = 31;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [30:0] FOLD_LIMIT = 31'd759250124;
	localparam logic signed [DW-1:0] X_START = 36'sd395948876;
	localparam logic signed [DW-1:0] HALF_PI = 36'sd1686629713;

	typedef struct packed {
		logic             negative;
		logic             zero;
		logic             folded;
	} acd_flags_t;

	function automatic logic signed [DW-1:0] atan_q30(input int k);
		logic [29:0] t;
		case (k)
			0: t = 30'd843314856;
			1: t = 30'd497837829;
			2: t = 30'd263043836;
			3: t = 30'd133525158;
			4: t = 30'd67021686;
			5: t = 30'd33543515;
			6: t = 30'd16775850;
			7: t = 30'd8388437;
			8: t = 30'd4194282;
			9: t = 30'd2097149;
			default: t = 30'((64'd1 << (30 - k)) - 64'd1);
		endcase
		return DW'(signed'({1'b0, t}));
	endfunction
endpackage
`default_nettype wire

### hdl/arcsine_double_cordic_unit.sv
`default_nettype none
// Arcsine unit, fully pipelined.
// s_axis: tdata = sine_value, signed Q2.30, item accepted on tvalid & tready.
// m_axis: tdata = angle in radians, signed Q2.30, within [-pi/2, pi/2].
// Pipeline: 1 input stage, 32 square-root stages, 2*ITERATIONS CORDIC stages
// and an output register, the same path for every value. Throughput is one
// item per cycle while the receiver does not stall.
// The square root runs on every item; unfolded items pass through it.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, it freezes and s_axis_tready falls, nothing lost.
// Reset clears all valid bits; no item is in flight after reset.
// Saturation: inputs beyond +-1 clamp to +-1, zero gives exactly zero.
module arcsine_double_cordic_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata, // [31:0] sine_value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata  // [31:0] angle
);
	import acd_pkg::*;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [30:0] mag;
	logic [31:0] neg;
	acd_flags_t  f0;
	always_comb begin
		neg = -s_axis_tdata;
		mag = s_axis_tdata[31] ? ((neg > 32'(ONE_Q30)) ? ONE_Q30 : neg[30:0])
			: ((s_axis_tdata > 32'(ONE_Q30)) ? ONE_Q30 : s_axis_tdata[30:0]);
		f0.negative = s_axis_tdata[31];
		f0.zero     = s_axis_tdata == '0;
		f0.folded   = mag > FOLD_LIMIT;
	end

	logic        v_q;
	logic [30:0] t_q;
	acd_flags_t  f_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (en) v_q <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_q <= mag;
			f_q <= f0;
		end
	end

	logic        sv;
	logic [30:0] st;
	acd_flags_t  sf;
	acd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_q), .tin(t_q), .fin(f_q),
		.vout(sv), .tout(st), .fout(sf)
	);

	logic        cv;
	logic [31:0] ca;
	acd_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(sv), .tin(st), .fin(sf),
		.vout(cv), .angle(ca)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= cv;
	end
	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= ca;
	end
endmodule
`default_nettype wire

### hdl/acd_sqrt.sv
`default_nettype none
// Pipelined restoring square root of 2^60 - t*t, one result bit per stage.
module acd_sqrt (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vin,
	input  wire logic [30:0]      tin,
	input  wire acd_pkg::acd_flags_t fin,
	output logic                  vout,
	output logic [30:0]           tout,
	output acd_pkg::acd_flags_t   fout
);
	import acd_pkg::*;

	logic [61:0] sq_s1;
	logic [30:0] t_s1;
	logic        v_s1;
	acd_flags_t  f_s1;

	logic [62:0] rem_s [SQ_STEPS+1];
	logic [31:0] root_s [SQ_STEPS+1];
	logic [30:0] t_p [SQ_STEPS+1];
	acd_flags_t  f_p [SQ_STEPS+1];
	logic        v_p [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= 62'(tin) * 62'(tin);
			t_s1  <= tin;
			f_s1  <= fin;
		end
	end

	always_comb begin
		rem_s[0]  = 63'((63'd1 << 60) - {1'b0, sq_s1});
		root_s[0] = '0;
		t_p[0]    = t_s1;
		f_p[0]    = f_s1;
		v_p[0]    = v_s1;
	end

	// root bit 30-i; rem compared against (4*root+1) << 2*(30-i)
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		logic [62:0] trial;
		logic [62:0] rem_n;
		logic [31:0] root_n;
		always_comb begin
			trial = (63'({root_s[i], 2'b01})) << (2 * (30 - i));
			if (rem_s[i] >= trial) begin
				rem_n  = rem_s[i] - trial;
				root_n = {root_s[i][30:0], 1'b1};
			end else begin
				rem_n  = rem_s[i];
				root_n = {root_s[i][30:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[i+1] <= 1'b0;
			else if (en) v_p[i+1] <= v_p[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= rem_n;
				root_s[i+1] <= root_n;
				t_p[i+1]    <= t_p[i];
				f_p[i+1]    <= f_p[i];
			end
		end
	end

	assign vout = v_p[SQ_STEPS];
	assign fout = f_p[SQ_STEPS];
	assign tout = f_p[SQ_STEPS].folded ? root_s[SQ_STEPS][30:0] : t_p[SQ_STEPS];
endmodule
`default_nettype wire

### hdl/acd_cordic.sv
`default_nettype none
// Double-rotation CORDIC, one register stage per pseudo-rotation.
module acd_cordic (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vin,
	input  wire logic [30:0]      tin,
	input  wire acd_pkg::acd_flags_t fin,
	output logic                  vout,
	output logic [31:0]           angle
);
	import acd_pkg::*;
	localparam int NR = 2 * STEPS;

	logic signed [DW-1:0] x_p [NR+1];
	logic signed [DW-1:0] y_p [NR+1];
	logic signed [DW-1:0] z_p [NR+1];
	logic [30:0]          t_p [NR+1];
	acd_flags_t           f_p [NR+1];
	logic                 v_p [NR+1];

	always_comb begin
		x_p[0] = X_START;
		y_p[0] = '0;
		z_p[0] = '0;
		t_p[0] = tin;
		f_p[0] = fin;
		v_p[0] = vin;
	end

	for (genvar r = 0; r < NR; r++) begin : g_rot
		localparam int K = r / 2;
		logic up;
		assign up = y_p[r] < DW'(signed'({1'b0, t_p[r]}));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[r+1] <= 1'b0;
			else if (en) v_p[r+1] <= v_p[r];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_p[r+1] <= up ? x_p[r] - (y_p[r] >>> K) : x_p[r] + (y_p[r] >>> K);
				y_p[r+1] <= up ? y_p[r] + (x_p[r] >>> K) : y_p[r] - (x_p[r] >>> K);
				z_p[r+1] <= up ? z_p[r] + atan_q30(K) : z_p[r] - atan_q30(K);
				t_p[r+1] <= t_p[r];
				f_p[r+1] <= f_p[r];
			end
		end
	end

	logic signed [DW-1:0] z_f, z_n;
	always_comb begin
		z_f = f_p[NR].folded ? HALF_PI - z_p[NR] : z_p[NR];
		z_n = f_p[NR].negative ? -z_f : z_f;
		if (z_n > HALF_PI) z_n = HALF_PI;
		if (z_n < -HALF_PI) z_n = -HALF_PI;
		if (f_p[NR].zero) z_n = '0;
	end
	assign vout  = v_p[NR];
	assign angle = z_n[31:0];
endmodule
`default_nettype wire
